// ----- sv/quad_diagonal_triangulator_defines.svh -----
// Assertion macros used by the quad triangulator checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef QUAD_DIAGONAL_TRIANGULATOR_DEFINES_SVH
`define QUAD_DIAGONAL_TRIANGULATOR_DEFINES_SVH

// same-cycle implication
`define QDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qdt_pkg.sv -----
// Shared constants and types of the quad triangulator.
// No dependencies.
`timescale 1ns / 1ps

package qdt_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int NUM_VERT       = 4;
    localparam int NUM_COORD      = 2 * NUM_VERT;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic {
        SPLIT_N0N2 = 1'b0,
        SPLIT_N1N3 = 1'b1
    } split_t;

endpackage

// ----- sv/qdt_front.sv -----
// Front pipeline: rotation to the smallest vertex, diagonal and orientation
// products, split decision. Depends on qdt_pkg.
`timescale 1ns / 1ps

module qdt_front #(
    parameter int COORD_BITS = qdt_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [qdt_pkg::NUM_COORD-1:0][COORD_BITS-1:0]   in_coord,
    output logic                                            q_valid,
    input  logic                                            q_ready,
    output logic [qdt_pkg::NUM_COORD-1:0][COORD_BITS-1:0]   q_coord,
    output qdt_pkg::split_t                                 q_split
);

    localparam int NC    = qdt_pkg::NUM_COORD;
    localparam int VI    = $clog2(qdt_pkg::NUM_VERT);
    localparam int MW    = COORD_BITS + 1;
    localparam int LW    = (MW + 1) / 2;
    localparam int HW    = MW - LW;
    localparam int LL_W  = 2 * LW;
    localparam int LH_W  = LW + HW;
    localparam int HH_W  = 2 * HW;
    localparam int PW    = 2 * MW;
    localparam int SW    = PW + 1;
    localparam int NPROD = 6;

    localparam int P_D02X = 0;
    localparam int P_D02Y = 1;
    localparam int P_D13X = 2;
    localparam int P_D13Y = 3;
    localparam int P_ORP  = 4;
    localparam int P_ORQ  = 5;

    typedef logic [NC-1:0][COORD_BITS-1:0] coords_t;

    function automatic logic lex_lt(input logic [COORD_BITS-1:0] ax,
                                    input logic [COORD_BITS-1:0] ay,
                                    input logic [COORD_BITS-1:0] bx,
                                    input logic [COORD_BITS-1:0] by);
        return ($signed(ax) < $signed(bx)) ||
               ((ax == bx) && ($signed(ay) < $signed(by)));
    endfunction

    // q - p at one extra bit
    function automatic logic [MW-1:0] sdiff(input logic [COORD_BITS-1:0] p,
                                            input logic [COORD_BITS-1:0] q);
        return {q[COORD_BITS-1], q} - {p[COORD_BITS-1], p};
    endfunction

    function automatic logic [MW-1:0] smag(input logic [MW-1:0] d);
        return d[MW-1] ? (MW'(0) - d) : d;
    endfunction

    logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv, s6_adv;

    logic    s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    coords_t s1_c_reg, s2_n_reg, s3_n_reg, s4_n_reg, s5_n_reg, s6_n_reg;
    coords_t s2_n_next;

    logic [MW-1:0]   s3_a_reg  [NPROD];
    logic [MW-1:0]   s3_b_reg  [NPROD];
    logic [LL_W-1:0] s4_ll_reg [NPROD];
    logic [LH_W-1:0] s4_lh_reg [NPROD];
    logic [LH_W-1:0] s4_hl_reg [NPROD];
    logic [HH_W-1:0] s4_hh_reg [NPROD];
    logic [PW-1:0]   s5_p_reg  [NPROD];

    logic s3_np_reg, s3_nq_reg, s4_np_reg, s4_nq_reg, s5_np_reg, s5_nq_reg;

    logic [SW-1:0]        s6_d02_reg, s6_d13_reg;
    logic signed [PW-1:0] s6_op_reg, s6_oq_reg;

    logic [MW-1:0] d02x, d02y, d13x, d13y, e1x, e1y;

    assign s6_adv   = !s6_v_reg || q_ready;
    assign s5_adv   = !s5_v_reg || s6_adv;
    assign s4_adv   = !s4_v_reg || s5_adv;
    assign s3_adv   = !s3_v_reg || s4_adv;
    assign s2_adv   = !s2_v_reg || s3_adv;
    assign s1_adv   = !s1_v_reg || s2_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_v_reg <= in_valid;
            if (s2_adv) s2_v_reg <= s1_v_reg;
            if (s3_adv) s3_v_reg <= s2_v_reg;
            if (s4_adv) s4_v_reg <= s3_v_reg;
            if (s5_adv) s5_v_reg <= s4_v_reg;
            if (s6_adv) s6_v_reg <= s5_v_reg;
        end
    end

    // smallest vertex: pairwise, earlier index kept on ties
    always_comb
    begin
        logic [VI-1:0] w01, w23, mi, sel;
        w01 = lex_lt(s1_c_reg[2], s1_c_reg[3], s1_c_reg[0], s1_c_reg[1])
              ? VI'(1) : VI'(0);
        w23 = lex_lt(s1_c_reg[6], s1_c_reg[7], s1_c_reg[4], s1_c_reg[5])
              ? VI'(3) : VI'(2);
        mi  = lex_lt(s1_c_reg[{w23, 1'b0}], s1_c_reg[{w23, 1'b1}],
                     s1_c_reg[{w01, 1'b0}], s1_c_reg[{w01, 1'b1}]) ? w23 : w01;
        s2_n_next = s1_c_reg;
        for (int i = 0; i < qdt_pkg::NUM_VERT; i++)
        begin
            sel = mi + VI'(i);
            s2_n_next[2 * i]     = s1_c_reg[{sel, 1'b0}];
            s2_n_next[2 * i + 1] = s1_c_reg[{sel, 1'b1}];
        end
    end

    assign d02x = sdiff(s2_n_reg[0], s2_n_reg[4]);
    assign d02y = sdiff(s2_n_reg[1], s2_n_reg[5]);
    assign d13x = sdiff(s2_n_reg[2], s2_n_reg[6]);
    assign d13y = sdiff(s2_n_reg[3], s2_n_reg[7]);
    assign e1x  = sdiff(s2_n_reg[0], s2_n_reg[2]);
    assign e1y  = sdiff(s2_n_reg[1], s2_n_reg[3]);

    always_ff @(posedge clk)
    begin
        if (s1_adv) s1_c_reg <= in_coord;
        if (s2_adv) s2_n_reg <= s2_n_next;
        if (s3_adv)
        begin
            s3_n_reg         <= s2_n_reg;
            s3_a_reg[P_D02X] <= smag(d02x);
            s3_b_reg[P_D02X] <= smag(d02x);
            s3_a_reg[P_D02Y] <= smag(d02y);
            s3_b_reg[P_D02Y] <= smag(d02y);
            s3_a_reg[P_D13X] <= smag(d13x);
            s3_b_reg[P_D13X] <= smag(d13x);
            s3_a_reg[P_D13Y] <= smag(d13y);
            s3_b_reg[P_D13Y] <= smag(d13y);
            s3_a_reg[P_ORP]  <= smag(e1x);
            s3_b_reg[P_ORP]  <= smag(d02y);
            s3_a_reg[P_ORQ]  <= smag(e1y);
            s3_b_reg[P_ORQ]  <= smag(d02x);
            s3_np_reg        <= e1x[MW-1] ^ d02y[MW-1];
            s3_nq_reg        <= e1y[MW-1] ^ d02x[MW-1];
        end
        if (s4_adv)
        begin
            s4_n_reg  <= s3_n_reg;
            s4_np_reg <= s3_np_reg;
            s4_nq_reg <= s3_nq_reg;
            for (int k = 0; k < NPROD; k++)
            begin
                s4_ll_reg[k] <= LL_W'(s3_a_reg[k][LW-1:0]) * LL_W'(s3_b_reg[k][LW-1:0]);
                s4_lh_reg[k] <= LH_W'(s3_a_reg[k][LW-1:0]) * LH_W'(s3_b_reg[k][MW-1:LW]);
                s4_hl_reg[k] <= LH_W'(s3_a_reg[k][MW-1:LW]) * LH_W'(s3_b_reg[k][LW-1:0]);
                s4_hh_reg[k] <= HH_W'(s3_a_reg[k][MW-1:LW]) * HH_W'(s3_b_reg[k][MW-1:LW]);
            end
        end
        if (s5_adv)
        begin
            s5_n_reg  <= s4_n_reg;
            s5_np_reg <= s4_np_reg;
            s5_nq_reg <= s4_nq_reg;
            for (int k = 0; k < NPROD; k++)
            begin
                s5_p_reg[k] <= PW'(s4_ll_reg[k])
                             + (PW'(s4_lh_reg[k]) << LW)
                             + (PW'(s4_hl_reg[k]) << LW)
                             + (PW'(s4_hh_reg[k]) << (2 * LW));
            end
        end
        if (s6_adv)
        begin
            s6_n_reg   <= s5_n_reg;
            s6_d02_reg <= SW'(s5_p_reg[P_D02X]) + SW'(s5_p_reg[P_D02Y]);
            s6_d13_reg <= SW'(s5_p_reg[P_D13X]) + SW'(s5_p_reg[P_D13Y]);
            s6_op_reg  <= s5_np_reg ? $signed(PW'(0) - s5_p_reg[P_ORP])
                                    : $signed(s5_p_reg[P_ORP]);
            s6_oq_reg  <= s5_nq_reg ? $signed(PW'(0) - s5_p_reg[P_ORQ])
                                    : $signed(s5_p_reg[P_ORQ]);
        end
    end

    always_comb
    begin
        if (s6_d02_reg < s6_d13_reg)
            q_split = qdt_pkg::SPLIT_N0N2;
        else if (s6_d02_reg > s6_d13_reg)
            q_split = qdt_pkg::SPLIT_N1N3;
        else if (s6_op_reg >= s6_oq_reg)
            q_split = qdt_pkg::SPLIT_N0N2;
        else
            q_split = qdt_pkg::SPLIT_N1N3;
    end

    assign q_valid = s6_v_reg;
    assign q_coord = s6_n_reg;

endmodule

// ----- sv/qdt_queue.sv -----
// Small FIFO between the front pipeline and the triangle emitter.
// Depends on qdt_pkg.
`timescale 1ns / 1ps

module qdt_queue #(
    parameter int DATA_BITS = qdt_pkg::NUM_COORD * qdt_pkg::COORD_BITS_DEF + 1,
    parameter int DEPTH     = qdt_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [AW:0]          wr_ptr_reg, wr_ptr_next;
    logic [AW:0]          rd_ptr_reg, rd_ptr_next;
    logic                 push, pop;

    assign wr_ready = (wr_ptr_reg ^ rd_ptr_reg) != {1'b1, AW'(0)};
    assign rd_valid = wr_ptr_reg != rd_ptr_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (AW + 1)'(push);
    assign rd_ptr_next = rd_ptr_reg + (AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg[AW-1:0]] <= wr_data;
    end

endmodule

// ----- sv/qdt_back.sv -----
// Triangle emitter: turns one split quad into two output transactions
// through an output register. Depends on qdt_pkg.
`timescale 1ns / 1ps

module qdt_back #(
    parameter int COORD_BITS = qdt_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            head_valid,
    output logic                                            head_ready,
    input  logic [qdt_pkg::NUM_COORD-1:0][COORD_BITS-1:0]   head_coord,
    input  qdt_pkg::split_t                                 head_split,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [COORD_BITS-1:0]                           ax,
    output logic [COORD_BITS-1:0]                           ay,
    output logic [COORD_BITS-1:0]                           bx,
    output logic [COORD_BITS-1:0]                           by,
    output logic [COORD_BITS-1:0]                           cx,
    output logic [COORD_BITS-1:0]                           cy,
    output logic                                            last
);

    localparam int VI = $clog2(qdt_pkg::NUM_VERT);

    typedef enum logic [1:0] {
        TRI_FIRST  = 2'b01,
        TRI_SECOND = 2'b10
    } tri_state_t;

    tri_state_t              state_reg, state_next;
    logic                    o_v_reg;
    logic [COORD_BITS-1:0]   ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic                    last_reg;
    logic                    out_load, emit;
    logic [VI-1:0]           ia, ib, ic;

    assign out_load   = !o_v_reg || out_ready;
    assign emit       = head_valid && out_load;
    assign head_ready = emit && (state_reg == TRI_SECOND);

    always_comb
    begin
        state_next = state_reg;
        ia = VI'(0);
        ib = VI'(1);
        ic = VI'(2);
        case (state_reg)
            TRI_FIRST:
            begin
                ic = (head_split == qdt_pkg::SPLIT_N0N2) ? VI'(2) : VI'(3);
                if (emit) state_next = TRI_SECOND;
            end
            TRI_SECOND:
            begin
                if (head_split == qdt_pkg::SPLIT_N0N2)
                begin
                    ia = VI'(0);
                    ib = VI'(2);
                end
                else
                begin
                    ia = VI'(1);
                    ib = VI'(2);
                end
                ic = VI'(3);
                if (emit) state_next = TRI_FIRST;
            end
            default:
            begin
                state_next = TRI_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TRI_FIRST;
            o_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load) o_v_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ax_reg   <= head_coord[{ia, 1'b0}];
            ay_reg   <= head_coord[{ia, 1'b1}];
            bx_reg   <= head_coord[{ib, 1'b0}];
            by_reg   <= head_coord[{ib, 1'b1}];
            cx_reg   <= head_coord[{ic, 1'b0}];
            cy_reg   <= head_coord[{ic, 1'b1}];
            last_reg <= (state_reg == TRI_SECOND);
        end
    end

    assign out_valid = o_v_reg;
    assign ax        = ax_reg;
    assign ay        = ay_reg;
    assign bx        = bx_reg;
    assign by        = by_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign last      = last_reg;

endmodule

// ----- sv/quad_diagonal_triangulator.sv -----
// Quad triangulator top: front pipeline, queue, triangle emitter.
// The first triangle of a quad passes the front stages, the queue and the output register.
// Each quad yields two triangles, both on the single result channel.
// The front takes a quad every cycle until the 4-entry queue and its own stages fill.
// Reset: asynchronous, clears all valid bits, queue pointers and emitter state.
// Depends on qdt_pkg, qdt_front, qdt_queue, qdt_back.
`timescale 1ns / 1ps

module quad_diagonal_triangulator #(
    parameter int COORD_BITS = qdt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  x0,
    input  logic signed [COORD_BITS-1:0]  y0,
    input  logic signed [COORD_BITS-1:0]  x1,
    input  logic signed [COORD_BITS-1:0]  y1,
    input  logic signed [COORD_BITS-1:0]  x2,
    input  logic signed [COORD_BITS-1:0]  y2,
    input  logic signed [COORD_BITS-1:0]  x3,
    input  logic signed [COORD_BITS-1:0]  y3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  ax,
    output logic signed [COORD_BITS-1:0]  ay,
    output logic signed [COORD_BITS-1:0]  bx,
    output logic signed [COORD_BITS-1:0]  by,
    output logic signed [COORD_BITS-1:0]  cx,
    output logic signed [COORD_BITS-1:0]  cy,
    output logic                          last
);

    localparam int NC   = qdt_pkg::NUM_COORD;
    localparam int QW   = NC * COORD_BITS + 1;

    logic [NC-1:0][COORD_BITS-1:0] in_coord, f_coord;
    qdt_pkg::split_t               f_split;
    logic                          f_valid, f_ready;
    logic [QW-1:0]                 q_wdata, q_rdata;
    logic                          h_valid, h_ready;
    logic [COORD_BITS-1:0]         o_ax, o_ay, o_bx, o_by, o_cx, o_cy;

    assign in_coord = {y3, x3, y2, x2, y1, x1, y0, x0};
    assign q_wdata  = {f_split, f_coord};

    qdt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_coord (in_coord),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_coord  (f_coord),
        .q_split  (f_split)
    );

    qdt_queue #(
        .DATA_BITS (QW),
        .DEPTH     (qdt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wdata),
        .rd_valid (h_valid),
        .rd_ready (h_ready),
        .rd_data  (q_rdata)
    );

    qdt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (h_valid),
        .head_ready (h_ready),
        .head_coord (q_rdata[QW-2:0]),
        .head_split (qdt_pkg::split_t'(q_rdata[QW-1])),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ax         (o_ax),
        .ay         (o_ay),
        .bx         (o_bx),
        .by         (o_by),
        .cx         (o_cx),
        .cy         (o_cy),
        .last       (last)
    );

    assign ax = $signed(o_ax);
    assign ay = $signed(o_ay);
    assign bx = $signed(o_bx);
    assign by = $signed(o_by);
    assign cx = $signed(o_cx);
    assign cy = $signed(o_cy);

endmodule

// ----- sv/qdt_checker.sv -----
// Port-level checks on the triangle result channel, bound to the top level.
// Depends on quad_diagonal_triangulator_defines.svh and qdt_pkg.
`timescale 1ns / 1ps
`include "quad_diagonal_triangulator_defines.svh"

module qdt_checker #(
    parameter int COORD_BITS = qdt_pkg::COORD_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_BITS-1:0]  ax,
    input logic signed [COORD_BITS-1:0]  ay,
    input logic signed [COORD_BITS-1:0]  bx,
    input logic signed [COORD_BITS-1:0]  by,
    input logic signed [COORD_BITS-1:0]  cx,
    input logic signed [COORD_BITS-1:0]  cy,
    input logic                          last
);

    `QDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ax) && $stable(ay) && $stable(bx) && $stable(by) && $stable(cx) && $stable(cy) && $stable(last), "qdt: stalled result transaction changed")

    `QDT_ASSERT_NEXT(a_second_follows, out_valid && out_ready && !last, out_valid && last, "qdt: second triangle did not follow the first")

    `QDT_ASSERT_NEXT(a_shared_diag, out_valid && out_ready && !last, (bx == $past(cx) && by == $past(cy)) || (cx == $past(cx) && cy == $past(cy)), "qdt: triangles do not share the split diagonal")

    `QDT_ASSERT_NOW(a_first_corner_min, out_valid && !last, !(($signed(bx) < $signed(ax)) || (bx == ax && $signed(by) < $signed(ay))), "qdt: first corner is not the smallest vertex")

endmodule

bind quad_diagonal_triangulator qdt_checker #(.COORD_BITS(COORD_BITS)) u_qdt_checker (.*);
